/* design/sos_pkg.sv */
// Shared types and constants for the SSD overlap search block.
`default_nettype none

package sos_pkg;

  // Sample and accumulator widths
  localparam int unsigned SampleBits = 16;
  localparam int unsigned DiffBits   = SampleBits + 1;
  localparam int unsigned MagBits    = SampleBits;
  localparam int unsigned SqBits     = 2 * MagBits;
  localparam int unsigned SumBits    = 48;

  // Slice counts and offset
  localparam int unsigned HBits    = 11;
  localparam int unsigned OffsBits = 12;
  localparam logic [HBits-1:0] TopHeightReset = HBits'(256);

  // Divider: one quotient bit per cycle
  localparam int unsigned DivSteps = SumBits;
  localparam int unsigned CntBits  = $clog2(DivSteps);

  // Stream payload layout, lowest field first
  localparam int unsigned InTopLsb    = 0;
  localparam int unsigned InBotLsb    = InTopLsb + SampleBits;
  localparam int unsigned InOvLsb     = InBotLsb + SampleBits;
  localparam int unsigned InUsedBits  = InOvLsb + HBits;
  localparam int unsigned InDataBits  = ((InUsedBits + 7) / 8) * 8;
  localparam int unsigned OutUsedBits = SumBits + HBits + HBits + OffsBits;
  localparam int unsigned OutDataBits = ((OutUsedBits + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV,
    ST_SCORE
  } sos_state_e;

  typedef struct packed {
    logic                 start;
    logic [SumBits-1:0]   dividend;
    logic [HBits-1:0]     divisor;
  } sos_div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sos_div_sts_t;

endpackage

`default_nettype wire

/* design/ssd_overlap_search_core.sv */
// Top level: SSD accumulation, candidate scoring and best-overlap tracking.
`default_nettype none

// Sum-of-squared-differences overlap search. Each input transfer is one voxel
// pair of a candidate overlap; tlast closes the candidate and tuser (on that
// same transfer) closes the whole search. The squared difference is added to
// a 48-bit accumulator that saturates at all ones. When a candidate closes,
// the sum is divided by its overlap (floor; overlap zero scores all ones), the
// lowest score under a strict less-than test is kept with its overlap, and one
// result transfer carries score, candidate overlap, best overlap and
// best_offset = top_height - best overlap. After a result with search_done the
// best score and overlap return to their reset values. Flow: a pair that does
// not close a candidate passes capture/subtract, square and accumulate before
// the next pair is taken. A closing pair then goes through the bit-serial
// divider, which produces one quotient bit per cycle for all 48 bits and then
// raises its done flag, and a scoring step that waits while the result
// register still holds an untaken result. That single result register lets
// the next candidate's pairs be taken while a result waits downstream.
// top_height is written through cfg_we_i/cfg_wdata_i and must only change while
// the block is idle.

module ssd_overlap_search_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration: top_height
  input  wire logic                               cfg_we_i,
  input  wire logic [sos_pkg::HBits-1:0]          cfg_wdata_i,
  // voxel pair stream
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // tdata: voxel_top[15:0], voxel_bottom[31:16], overlap[42:32], zero pad
  input  wire logic [sos_pkg::InDataBits-1:0]     s_axis_tdata_i,
  input  wire logic                               s_axis_tlast_i,  // last_of_candidate
  input  wire logic                               s_axis_tuser_i,  // last_of_search
  // result stream
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // tdata: score[47:0], candidate_overlap[58:48], best_overlap[69:59],
  //        best_offset[81:70], zero pad
  output logic [sos_pkg::OutDataBits-1:0]         m_axis_tdata_o,
  output logic                                    m_axis_tlast_o   // search_done
);

  localparam int unsigned SB = sos_pkg::SampleBits;
  localparam int unsigned HB = sos_pkg::HBits;

  sos_pkg::sos_state_e state_q, state_d;

  // control
  logic in_xfer;
  logic div_start;
  logic score_load;
  logic out_free;

  // configuration
  logic [HB-1:0] top_height_q;

  // per-item payload
  logic signed [sos_pkg::DiffBits-1:0] diff_q, diff_d;
  logic [HB-1:0]                       ov_q;
  logic                                last_cand_q;
  logic                                last_search_q;
  logic [sos_pkg::SqBits-1:0]          sq_q, sq_d;
  logic [sos_pkg::DiffBits-1:0]        mag_full;
  logic [sos_pkg::MagBits-1:0]         mag;

  // accumulator and search state
  logic [sos_pkg::SumBits-1:0]         diff_sum_q, diff_sum_d;
  logic [sos_pkg::SumBits:0]           sum_wide;
  logic [sos_pkg::SumBits-1:0]         sum_sat;
  logic [sos_pkg::SumBits-1:0]         lowest_q, lowest_d;
  logic [HB-1:0]                       best_q, best_d;
  logic [sos_pkg::SumBits-1:0]         score;
  logic                                better;
  logic [sos_pkg::OffsBits-1:0]        offset;

  // divider
  sos_pkg::sos_div_req_t               div_req;
  sos_pkg::sos_div_sts_t               div_sts;

  // result register
  logic                                m_valid_q, m_valid_d;
  logic [sos_pkg::OutDataBits-1:0]     m_data_q;
  logic                                m_last_q;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sos_pkg::ST_IDLE:   if (in_xfer) state_d = sos_pkg::ST_SQUARE;
      sos_pkg::ST_SQUARE: state_d = sos_pkg::ST_ACCUM;
      sos_pkg::ST_ACCUM:  state_d = last_cand_q ? sos_pkg::ST_DIV : sos_pkg::ST_IDLE;
      sos_pkg::ST_DIV:    if (div_sts.done) state_d = sos_pkg::ST_SCORE;
      sos_pkg::ST_SCORE:  if (out_free) state_d = sos_pkg::ST_IDLE;
      default:            state_d = sos_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    score_load      = 1'b0;
    case (state_q)
      sos_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      sos_pkg::ST_ACCUM: div_start = last_cand_q;
      sos_pkg::ST_SCORE: score_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath: difference, square, saturating accumulate
  // ---------------------------------------------------------------------------
  assign diff_d = {s_axis_tdata_i[sos_pkg::InTopLsb+SB-1], s_axis_tdata_i[sos_pkg::InTopLsb +: SB]}
                - {s_axis_tdata_i[sos_pkg::InBotLsb+SB-1], s_axis_tdata_i[sos_pkg::InBotLsb +: SB]};

  // |diff| is at most 2^SB - 1, so it fits SB bits
  assign mag_full = diff_q[sos_pkg::DiffBits-1] ? sos_pkg::DiffBits'(-diff_q)
                                                 : sos_pkg::DiffBits'(diff_q);
  assign mag      = mag_full[sos_pkg::MagBits-1:0];
  assign sq_d     = mag * mag;

  assign sum_wide = {1'b0, diff_sum_q} + (sos_pkg::SumBits + 1)'(sq_q);
  assign sum_sat  = sum_wide[sos_pkg::SumBits] ? '1 : sum_wide[sos_pkg::SumBits-1:0];

  always_comb begin
    diff_sum_d = diff_sum_q;
    if (state_q == sos_pkg::ST_ACCUM) begin
      // closing pair: sum goes to the divider, accumulator restarts
      diff_sum_d = last_cand_q ? '0 : sum_sat;
    end
  end

  assign div_req.start    = div_start;
  assign div_req.dividend = sum_sat;
  assign div_req.divisor  = ov_q;

  sos_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .quotient_o (score),
    .sts_o      (div_sts)
  );

  // ---------------------------------------------------------------------------
  // Best candidate tracking
  // ---------------------------------------------------------------------------
  assign better = score < lowest_q;
  assign offset = {1'b0, top_height_q} - {1'b0, best_d};

  always_comb begin
    best_d   = best_q;
    lowest_d = lowest_q;
    if (score_load && better) begin
      best_d   = ov_q;
      lowest_d = score;
    end
  end

  assign m_valid_d = score_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sos_pkg::ST_IDLE;
      top_height_q <= sos_pkg::TopHeightReset;
      diff_sum_q   <= '0;
      lowest_q     <= '1;
      best_q       <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      diff_sum_q <= diff_sum_d;
      m_valid_q  <= m_valid_d;
      if (cfg_we_i) begin
        top_height_q <= cfg_wdata_i;
      end
      if (score_load && last_search_q) begin
        lowest_q <= '1;
        best_q   <= '0;
      end else begin
        lowest_q <= lowest_d;
        best_q   <= best_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      diff_q        <= diff_d;
      ov_q          <= s_axis_tdata_i[sos_pkg::InOvLsb +: HB];
      last_cand_q   <= s_axis_tlast_i;
      last_search_q <= s_axis_tuser_i;
    end
    if (state_q == sos_pkg::ST_SQUARE) begin
      sq_q <= sq_d;
    end
    if (score_load) begin
      m_data_q <= sos_pkg::OutDataBits'({offset, best_d, ov_q, score});
      m_last_q <= last_search_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_while_dividing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_sts.busy
  ) else $error("input taken while divider busy");

  a_result_never_overwritten: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    score_load |-> (!m_valid_q || m_axis_tready_i)
  ) else $error("result register overwritten before transfer");

  a_div_done_in_div_state: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> (state_q == sos_pkg::ST_DIV)
  ) else $error("divider finished outside division phase");

  a_search_cleared: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (score_load && last_search_q) |=> (lowest_q == '1 && best_q == '0)
  ) else $error("search state not cleared after closing result");

endmodule

`default_nettype wire

/* design/sos_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none

module sos_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sos_pkg::sos_div_req_t             req_i,
  output logic [sos_pkg::SumBits-1:0]            quotient_o,
  output sos_pkg::sos_div_sts_t                  sts_o
);

  logic [sos_pkg::SumBits-1:0] quo_q, quo_d;
  logic [sos_pkg::HBits-1:0]   rem_q, rem_d;
  logic [sos_pkg::HBits-1:0]   div_q, div_d;
  logic [sos_pkg::CntBits-1:0] cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  logic [sos_pkg::HBits:0]     shifted;
  logic [sos_pkg::HBits:0]     trial;
  logic                        fits;

  // Divisor zero: every trial fits, quotient comes out all ones.
  assign shifted = {rem_q, quo_q[sos_pkg::SumBits-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
      cnt_d  = sos_pkg::CntBits'(sos_pkg::DivSteps - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[sos_pkg::SumBits-2:0], fits};
      rem_d = fits ? trial[sos_pkg::HBits-1:0] : shifted[sos_pkg::HBits-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign quotient_o = quo_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

`default_nettype wire
